/* rtl/core/cb64_pkg.sv */
// Shared types, constants and functions of the chunked Base64 / CRC-32 encoder.
// Used by every module of the block by scoped names; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cb64_pkg;

   localparam logic [31:0] CRC_POLY          = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT          = 32'hFFFF_FFFF;
   localparam logic [7:0]  PAD_CHAR          = 8'd61;
   localparam logic [7:0]  CHUNK_BYTES_RESET = 8'd93;
   localparam logic [5:0]  SEXTET_MASK       = 6'h3F;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic CSR_IDX_CHUNK_BYTES = 1'b0;

   localparam logic [1:0] GROUP_FULL = 2'd3;
   localparam logic [1:0] CHAR_LAST  = 2'd3;

   typedef struct packed {
      logic [23:0] triple;
      logic [1:0]  bytes;
      logic        chunk_end;
      logic [31:0] crc;
      logic [15:0] index;
   } group_type;

   function automatic logic [31:0] crc_update(input logic [31:0] crc_in,
                                              input logic [7:0]  data);
      logic [31:0] c;
      c = crc_in ^ {24'b0, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] c;
      logic [7:0] w;
      w = {2'b00, v & SEXTET_MASK};
      if (v < 6'd26) begin
         c = 8'd65 + w;
      end else if (v < 6'd52) begin
         c = 8'd71 + w;
      end else if (v < 6'd62) begin
         c = w - 8'd4;
      end else if (v == 6'd62) begin
         c = 8'd43;
      end else begin
         c = 8'd47;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/cb64_framer.sv */
// Chunk framing: byte count, group assembly, running CRC-32 and chunk index.
// Builds one group record per completed group or chunk end; uses cb64_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cb64_framer (
   input  wire                 clock,
   input  wire                 reset,
   input  wire  [7:0]          chunk_bytes,
   input  wire                 beat,
   input  wire  [7:0]          data_byte,
   input  wire                 end_of_image,
   output logic                push,
   output cb64_pkg::group_type group
);

   logic [15:0] held_ff,  held_in;
   logic [1:0]  fill_ff,  fill_in;
   logic [7:0]  count_ff, count_in;
   logic [31:0] crc_ff,   crc_in;
   logic [15:0] index_ff, index_in;

   logic [1:0]  n;
   logic [7:0]  cnt;
   logic        chunk_end;
   logic [31:0] crc_next;
   logic        emit;

   always_comb begin
      n         = fill_ff + 2'd1;
      cnt       = count_ff + 8'd1;
      chunk_end = end_of_image || (cnt == chunk_bytes);
      crc_next  = cb64_pkg::crc_update(crc_ff, data_byte);
      emit      = (n == cb64_pkg::GROUP_FULL) || chunk_end;

      case (n)
         2'd3:    group.triple = {held_ff, data_byte};
         2'd2:    group.triple = {held_ff[7:0], data_byte, 8'h00};
         default: group.triple = {data_byte, 16'h0000};
      endcase
      group.bytes     = n;
      group.chunk_end = chunk_end;
      group.crc       = crc_next ^ cb64_pkg::CRC_INIT;
      group.index     = index_ff;
      push            = beat && emit;

      held_in  = held_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      crc_in   = crc_ff;
      index_in = index_ff;
      if (beat) begin
         if (chunk_end) begin
            held_in  = 16'h0000;
            fill_in  = 2'd0;
            count_in = 8'd0;
            crc_in   = cb64_pkg::CRC_INIT;
            index_in = index_ff + 16'd1;
         end else begin
            count_in = cnt;
            crc_in   = crc_next;
            if (emit) begin
               held_in = 16'h0000;
               fill_in = 2'd0;
            end else begin
               held_in = {held_ff[7:0], data_byte};
               fill_in = n;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 16'h0000;
         fill_ff  <= 2'd0;
         count_ff <= 8'd0;
         crc_ff   <= cb64_pkg::CRC_INIT;
         index_ff <= 16'd0;
      end else begin
         held_ff  <= held_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
         crc_ff   <= crc_in;
         index_ff <= index_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/cb64_group_fifo.sv */
// Two-entry queue of group records between the framer and the serializer.
// Entries are cb64_pkg::group_type registers with read and write pointers.
`timescale 1ns / 1ps
`default_nettype none

module cb64_group_fifo (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  cb64_pkg::group_type push_group,
   input  wire                 pop,
   output logic                full,
   output logic                not_empty,
   output cb64_pkg::group_type head
);

   cb64_pkg::group_type entry_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff,  count_in;

   always_comb begin
      full      = (count_ff == 2'd2);
      not_empty = (count_ff != 2'd0);
      head      = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/cb64_serializer.sv */
// Turns the head group record into four characters, one per beat, into the
// registered result stage; uses cb64_pkg for the alphabet and pad character.
`timescale 1ns / 1ps
`default_nettype none

module cb64_serializer (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 group_valid,
   input  cb64_pkg::group_type group,
   output logic                pop,
   output logic                out_valid,
   input  wire                 out_stall,
   output logic [7:0]          out_char,
   output logic                last_of_group,
   output logic                end_of_chunk,
   output logic [31:0]         chunk_crc,
   output logic [15:0]         chunk_index
);

   logic [1:0]  k_ff, k_in;
   logic        valid_ff, valid_in;
   logic [7:0]  char_ff, char_in;
   logic        last_ff, last_in;
   logic        eoc_ff, eoc_in;
   logic [31:0] crc_ff, crc_in;
   logic [15:0] index_ff, index_in;

   logic       load;
   logic [5:0] sextet;

   always_comb begin
      load = group_valid && (!valid_ff || !out_stall);
      pop  = load && (k_ff == cb64_pkg::CHAR_LAST);

      case (k_ff)
         2'd0:    sextet = group.triple[23:18];
         2'd1:    sextet = group.triple[17:12];
         2'd2:    sextet = group.triple[11:6];
         default: sextet = group.triple[5:0];
      endcase

      char_in  = (k_ff <= group.bytes) ? cb64_pkg::b64_char(sextet) : cb64_pkg::PAD_CHAR;
      last_in  = (k_ff == cb64_pkg::CHAR_LAST);
      eoc_in   = last_in && group.chunk_end;
      crc_in   = eoc_in ? group.crc : 32'h0;
      index_in = group.index;
      k_in     = load ? k_ff + 2'd1 : k_ff;
      valid_in = load || (valid_ff && out_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         k_ff     <= k_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff  <= char_in;
         last_ff  <= last_in;
         eoc_ff   <= eoc_in;
         crc_ff   <= crc_in;
         index_ff <= index_in;
      end
   end

   assign out_valid     = valid_ff;
   assign out_char      = char_ff;
   assign last_of_group = last_ff;
   assign end_of_chunk  = eoc_ff;
   assign chunk_crc     = crc_ff;
   assign chunk_index   = index_ff;

endmodule

`default_nettype wire

/* rtl/core/chunk_base64_crc32_encoder.sv */
// Top level of the chunked Base64 encoder with per-chunk CRC-32.
// Instantiates cb64_framer, cb64_group_fifo and cb64_serializer; uses cb64_pkg.
//
// Usage:
//   req_ channel: one raw byte per beat, req_end_of_image on the image's last byte.
//   rsp_ channel: one Base64 character per beat; every third byte of a chunk,
//   and every chunk end, gives four characters. The last of them carries
//   rsp_last_of_group, and at a chunk end rsp_end_of_chunk with the CRC-32.
//   rsp_chunk_index numbers the chunks from 0, wrapping at 65536.
//   csr_ port: register 0 at address 0 is chunk_bytes (reset 93).
// Timing:
//   A byte that closes a group goes into the two-entry group queue, then
//   its first character shows from the serializer's result register; one
//   character per cycle follows while rsp_stall is low. Bytes are taken in every
//   cycle while the queue has room; the serializer sets the sustained rate.
// Reset clears the chunk state and the queue; chunk_bytes returns to 93.
// When the receiver stalls, the result register holds; the queue then fills
// and req_stall rises until a group drains.
`timescale 1ns / 1ps
`default_nettype none

module chunk_base64_crc32_encoder (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [7:0]                       req_data_byte,
   input  wire                              req_end_of_image,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [7:0]                       rsp_out_char,
   output logic                             rsp_last_of_group,
   output logic                             rsp_end_of_chunk,
   output logic [31:0]                      rsp_chunk_crc,
   output logic [15:0]                      rsp_chunk_index,
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire  [cb64_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire  [cb64_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [cb64_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   logic [7:0]          chunk_bytes_ff, chunk_bytes_in;
   logic                csr_hit;
   logic                req_beat;
   logic                push;
   cb64_pkg::group_type push_group;
   cb64_pkg::group_type head;
   logic                pop;
   logic                fifo_full;
   logic                fifo_not_empty;

   always_comb begin
      csr_pready     = 1'b1;
      csr_hit        = (csr_paddr[2] == cb64_pkg::CSR_IDX_CHUNK_BYTES);
      chunk_bytes_in = chunk_bytes_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         chunk_bytes_in = csr_pwdata[7:0];
      end
      csr_prdata = csr_hit ? {24'b0, chunk_bytes_ff} : '0;
      req_stall  = fifo_full;
      req_beat   = req_valid && !req_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_bytes_ff <= cb64_pkg::CHUNK_BYTES_RESET;
      end else begin
         chunk_bytes_ff <= chunk_bytes_in;
      end
   end

   cb64_framer u_framer (
      .clock        (clock),
      .reset        (reset),
      .chunk_bytes  (chunk_bytes_ff),
      .beat         (req_beat),
      .data_byte    (req_data_byte),
      .end_of_image (req_end_of_image),
      .push         (push),
      .group        (push_group)
   );

   cb64_group_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .pop        (pop),
      .full       (fifo_full),
      .not_empty  (fifo_not_empty),
      .head       (head)
   );

   cb64_serializer u_serializer (
      .clock         (clock),
      .reset         (reset),
      .group_valid   (fifo_not_empty),
      .group         (head),
      .pop           (pop),
      .out_valid     (rsp_valid),
      .out_stall     (rsp_stall),
      .out_char      (rsp_out_char),
      .last_of_group (rsp_last_of_group),
      .end_of_chunk  (rsp_end_of_chunk),
      .chunk_crc     (rsp_chunk_crc),
      .chunk_index   (rsp_chunk_index)
   );

endmodule

`default_nettype wire

/* rtl/core/cb64_checker.sv */
// Port-level checks of the chunked Base64 encoder, bound to the top level.
// Sees only the top-level ports; uses cb64_pkg for the pad character.
`timescale 1ns / 1ps
`default_nettype none

module cb64_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [7:0]  rsp_out_char,
   input wire        rsp_last_of_group,
   input wire [15:0] rsp_chunk_index
);

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char))
      else $error("stalled result beat changed");

   a_group_unbroken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_group |=> rsp_valid)
      else $error("gap inside a group of four characters");

   a_pad_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_group && rsp_out_char == cb64_pkg::PAD_CHAR
      |=> rsp_out_char == cb64_pkg::PAD_CHAR)
      else $error("data character after padding");

   a_index_in_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_group
      |=> rsp_chunk_index == $past(rsp_chunk_index))
      else $error("chunk index changed inside a group");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind chunk_base64_crc32_encoder cb64_checker u_cb64_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_out_char      (rsp_out_char),
   .rsp_last_of_group (rsp_last_of_group),
   .rsp_chunk_index   (rsp_chunk_index)
);

`default_nettype wire
